### rtl/oce_pkg.sv
// Shared types, codes and constants of the occupancy clearance erosion unit.
package oce_pkg;

    // default sizes handed to the top-level parameters
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_RADIUS_DEF = 15;

    // arithmetic widths, sized for the largest parameter values
    localparam int XY_W   = 14;  // signed coordinate math
    localparam int SQ_W   = 14;  // squared distances up to 2*63*63
    localparam int RAD_W  = 6;   // saturated radius
    localparam int DY_W   = 7;   // signed row offset
    localparam int MEM_AW = 12;  // row or column address

    // configuration register indexes
    localparam logic [2:0] CFG_GRID_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_OCC_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_UNKNOWN_BLK   = 3'd3;
    localparam logic [2:0] CFG_CLEARANCE     = 3'd4;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        cell_x;
        logic [7:0]        cell_y;
        logic signed [7:0] cell_cost;
    } t_in;

    typedef struct packed {
        logic is_answer;
        logic cell_safe;
    } t_out;

    // request from the sequencer to the row memory
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [MEM_AW-1:0] row;
        logic [MEM_AW-1:0] col;
        logic              wr_bit;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_Q_INIT,
        S_Q_ADJ,
        S_Q_READ,
        S_Q_CHK,
        S_DONE
    } t_state;

endpackage

### rtl/oce_row_mem.sv
// Blocked map storage: one map row per word, single-bit writes, full-row registered reads.
module oce_row_mem #(
    parameter int MAX_WIDTH  = oce_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = oce_pkg::MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  oce_pkg::t_mem_req    i_req,
    output logic [MAX_WIDTH-1:0] o_row
);

    localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [MAX_WIDTH-1:0] r_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.row[ROW_AW-1:0]][i_req.col[COL_AW-1:0]] <= i_req.wr_bit;
        end
        if (i_req.rd_en) begin
            r_row <= r_mem[i_req.row[ROW_AW-1:0]];
        end
    end

    assign o_row = r_row;

endmodule

### rtl/occupancy_clearance_erosion_unit.sv
// Top level: blocked map with disk-shaped clearance query, run by a row sequencer.
//
// Input channel i_valid/o_ready carries a t_in item: a write stores one cell as
// blocked or free, a query asks whether a cell and its clearance disk are free.
// Output channel o_valid/i_ready returns one t_out per item, in order.
// One item is in work at a time; o_ready is high only while the sequencer idles.
// A write passes through the write and done states before its acknowledge is registered.
// A query walks the disk one map row per cycle group: each row costs one
// half-width step on the shared add/compare unit, one row read and one check,
// plus up to 2*r extra half-width steps over the whole disk. A query stops early at
// the first blocked or off-map row. The single-port row memory sets the pace of this walk.
// A finished result sits in an output register; the next item is taken while it
// waits, and only the end of that next item stalls on a blocked receiver.
// Reset (synchronous, active low) returns the sequencer to idle, drops o_valid and
// loads the register defaults. The map itself is not cleared; every cell must be
// written before it is queried. Config writes are taken at any cycle.
module occupancy_clearance_erosion_unit #(
    parameter int MAX_WIDTH  = oce_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = oce_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = oce_pkg::MAX_RADIUS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  oce_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output oce_pkg::t_out  o_data,
    input  logic           i_cfg_wr_en,
    input  logic [2:0]     i_cfg_index,
    input  logic [8:0]     i_cfg_data
);

    localparam int XY_W  = oce_pkg::XY_W;
    localparam int SQ_W  = oce_pkg::SQ_W;
    localparam int RAD_W = oce_pkg::RAD_W;
    localparam int DY_W  = oce_pkg::DY_W;

    // configuration
    logic [8:0] r_grid_width;
    logic [8:0] r_grid_height;
    logic [6:0] r_occ_threshold;
    logic       r_unknown_blk;
    logic [3:0] r_clearance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width    <= 9'd256;
            r_grid_height   <= 9'd256;
            r_occ_threshold <= 7'd20;
            r_unknown_blk   <= 1'b1;
            r_clearance     <= 4'd4;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                oce_pkg::CFG_GRID_WIDTH:    r_grid_width    <= i_cfg_data;
                oce_pkg::CFG_GRID_HEIGHT:   r_grid_height   <= i_cfg_data;
                oce_pkg::CFG_OCC_THRESHOLD: r_occ_threshold <= i_cfg_data[6:0];
                oce_pkg::CFG_UNKNOWN_BLK:   r_unknown_blk   <= i_cfg_data[0];
                oce_pkg::CFG_CLEARANCE:     r_clearance     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // extents and radius, saturated to the built sizes
    logic signed [XY_W-1:0] used_w;
    logic signed [XY_W-1:0] used_h;
    logic [RAD_W-1:0]       sat_r;

    always_comb begin
        used_w = ({5'b0, r_grid_width} > XY_W'(MAX_WIDTH)) ?
                 XY_W'(MAX_WIDTH) : $signed({5'b0, r_grid_width});
        used_h = ({5'b0, r_grid_height} > XY_W'(MAX_HEIGHT)) ?
                 XY_W'(MAX_HEIGHT) : $signed({5'b0, r_grid_height});
        sat_r  = ({2'b0, r_clearance} > RAD_W'(MAX_RADIUS)) ?
                 RAD_W'(MAX_RADIUS) : {2'b0, r_clearance};
    end

    // sequencer state
    oce_pkg::t_state r_state, n_state;
    oce_pkg::t_in    r_item, n_item;
    logic [RAD_W-1:0]       r_r, n_r;
    logic [SQ_W-1:0]        r_r2, n_r2;
    logic signed [DY_W-1:0] r_dy, n_dy;
    logic [SQ_W-1:0]        r_dy2, n_dy2;
    logic [RAD_W-1:0]       r_hw, n_hw;
    logic [SQ_W-1:0]        r_hw2, n_hw2;
    logic                   r_safe, n_safe;
    logic                   r_out_valid, n_out_valid;
    oce_pkg::t_out          r_out, n_out;

    oce_pkg::t_mem_req      mem_req;
    logic [MAX_WIDTH-1:0]   mem_row;

    oce_row_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_row_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_row (mem_row)
    );

    // shared add/compare unit for the disk half-width
    logic                   grow;
    logic [SQ_W-1:0]        dist_sum;
    logic                   step_hw;

    // row window
    logic signed [XY_W-1:0] sx, sy, ny, lo, hi;
    logic                   row_in_map;
    logic                   win_in_map;
    logic                   win_blocked;
    logic                   wr_inside;
    logic                   wr_bit;
    logic signed [SQ_W:0]   dy2_step;

    always_comb begin
        sx   = $signed({{(XY_W-8){1'b0}}, r_item.cell_x});
        sy   = $signed({{(XY_W-8){1'b0}}, r_item.cell_y});
        ny   = sy + XY_W'(r_dy);
        lo   = sx - $signed({{(XY_W-RAD_W){1'b0}}, r_hw});
        hi   = sx + $signed({{(XY_W-RAD_W){1'b0}}, r_hw});
        row_in_map = (ny >= 0) && (ny < used_h);
        win_in_map = (lo >= 0) && (hi < used_w);
        win_blocked = 1'b0;
        for (int j = 0; j < MAX_WIDTH; j++) begin
            if (mem_row[j] && ($signed(XY_W'(j)) >= lo) && ($signed(XY_W'(j)) <= hi)) begin
                win_blocked = 1'b1;
            end
        end

        // growing half toward the center row tests (hw+1)^2, shrinking half tests hw^2
        grow     = (r_dy <= 0);
        dist_sum = r_hw2 + r_dy2 + (grow ? SQ_W'({r_hw, 1'b1}) : '0);
        step_hw  = grow ? (dist_sum <= r_r2) : (dist_sum > r_r2);

        // (dy+1)^2 = dy^2 + 2dy + 1
        dy2_step = $signed({1'b0, r_dy2}) +
                   $signed({{(SQ_W-DY_W){r_dy[DY_W-1]}}, r_dy, 1'b1});

        wr_inside = (sx < used_w) && (sy < used_h);
        wr_bit    = r_item.cell_cost[7] ? r_unknown_blk :
                    (r_item.cell_cost[6:0] >= r_occ_threshold);
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_r         = r_r;
        n_r2        = r_r2;
        n_dy        = r_dy;
        n_dy2       = r_dy2;
        n_hw        = r_hw;
        n_hw2       = r_hw2;
        n_safe      = r_safe;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_ready     = (r_state == oce_pkg::S_IDLE);

        mem_req        = '0;
        mem_req.row    = ny[oce_pkg::MEM_AW-1:0];
        mem_req.col    = {{(oce_pkg::MEM_AW-8){1'b0}}, r_item.cell_x};
        mem_req.wr_bit = wr_bit;

        case (r_state)
            oce_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_item  = i_data;
                    n_state = (i_data.req_type == oce_pkg::REQ_QUERY) ?
                              oce_pkg::S_Q_INIT : oce_pkg::S_WRITE;
                end
            end
            oce_pkg::S_WRITE: begin
                mem_req.row   = {{(oce_pkg::MEM_AW-8){1'b0}}, r_item.cell_y};
                mem_req.wr_en = wr_inside;
                n_safe        = 1'b0;
                n_state       = oce_pkg::S_DONE;
            end
            oce_pkg::S_Q_INIT: begin
                n_r     = sat_r;
                n_r2    = SQ_W'(sat_r) * SQ_W'(sat_r);
                n_dy    = -$signed({1'b0, sat_r});
                n_dy2   = SQ_W'(sat_r) * SQ_W'(sat_r);
                n_hw    = '0;
                n_hw2   = '0;
                n_state = oce_pkg::S_Q_ADJ;
            end
            oce_pkg::S_Q_ADJ: begin
                if (step_hw) begin
                    if (grow) begin
                        n_hw  = r_hw + 1'b1;
                        n_hw2 = r_hw2 + SQ_W'({r_hw, 1'b1});
                    end else begin
                        n_hw  = r_hw - 1'b1;
                        n_hw2 = r_hw2 - SQ_W'({r_hw - 1'b1, 1'b1});
                    end
                end else begin
                    n_state = oce_pkg::S_Q_READ;
                end
            end
            oce_pkg::S_Q_READ: begin
                if (row_in_map) begin
                    mem_req.rd_en = 1'b1;
                    n_state       = oce_pkg::S_Q_CHK;
                end else begin
                    n_safe  = 1'b0;
                    n_state = oce_pkg::S_DONE;
                end
            end
            oce_pkg::S_Q_CHK: begin
                if (!win_in_map || win_blocked) begin
                    n_safe  = 1'b0;
                    n_state = oce_pkg::S_DONE;
                end else if (r_dy == $signed({1'b0, r_r})) begin
                    n_safe  = 1'b1;
                    n_state = oce_pkg::S_DONE;
                end else begin
                    n_dy    = r_dy + 1'b1;
                    n_dy2   = dy2_step[SQ_W-1:0];
                    n_state = oce_pkg::S_Q_ADJ;
                end
            end
            oce_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.is_answer = (r_item.req_type == oce_pkg::REQ_QUERY);
                    n_out.cell_safe = r_safe;
                    n_state         = oce_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oce_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oce_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_r    <= n_r;
        r_r2   <= n_r2;
        r_dy   <= n_dy;
        r_dy2  <= n_dy2;
        r_hw   <= n_hw;
        r_hw2  <= n_hw2;
        r_safe <= n_safe;
        r_out  <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // a write acknowledge never reports a safe cell
    a_ack_not_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.is_answer) |-> !o_data.cell_safe)
        else $error("write acknowledge with cell_safe set");

    // only one item in work: an input transfer closes the input side
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an item is in work");

    // row data is checked in the cycle right after its read
    a_read_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == oce_pkg::S_Q_CHK) |-> ($past(r_state) == oce_pkg::S_Q_READ))
        else $error("row check without a preceding read");

    // the half-width settles on the disk edge before a row is read
    a_disk_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == oce_pkg::S_Q_READ) |->
            ((r_hw2 == SQ_W'(r_hw) * SQ_W'(r_hw)) && (r_hw2 + r_dy2 <= r_r2) &&
             (r_hw2 + SQ_W'({r_hw, 1'b1}) + r_dy2 > r_r2)))
        else $error("row half-width off the disk edge");

endmodule

### tb/occupancy_clearance_erosion_checker.sv
// Checker for the occupancy clearance erosion unit: tracks the blocked map and compares results.
module occupancy_clearance_erosion_checker
    import oce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  t_in        i_req,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_ready,
    input  t_out       i_rsp,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output int         o_mismatches,
    output int         o_results,
    output int         o_safe_answers
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_STRIDE = MAX_WIDTH_DEF;

    bit         blocked_cells [MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
    logic [8:0] map_cols;
    logic [8:0] map_rows;
    logic [6:0] cost_limit;
    logic       unknown_blocks;
    logic [3:0] clear_radius;
    t_out       answers_due [$];

    // extents above the array size saturate
    function automatic bit on_map(int x, int y);
        int cols;
        int rows;
        cols = (map_cols > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(map_cols);
        rows = (map_rows > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(map_rows);
        return x >= 0 && y >= 0 && x < cols && y < rows;
    endfunction

    // off-map cells count as blocked
    function automatic bit free_cell(int x, int y);
        return on_map(x, y) && !blocked_cells[y * ROW_STRIDE + x];
    endfunction

    function automatic bit has_clearance(int x, int y);
        int r;
        r = (clear_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(clear_radius);
        if (!free_cell(x, y)) begin
            return 1'b0;
        end
        for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
                if (dx * dx + dy * dy <= r * r && !free_cell(x + dx, y + dy)) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        int   cost;
        int   x;
        int   y;
        if (!i_rst_n) begin
            map_cols       = 9'd256;
            map_rows       = 9'd256;
            cost_limit     = 7'd20;
            unknown_blocks = 1'b1;
            clear_radius   = 4'd4;
            answers_due.delete();
            o_mismatches   <= 0;
            o_results      <= 0;
            o_safe_answers <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:    map_cols       = i_cfg_data;
                    CFG_GRID_HEIGHT:   map_rows       = i_cfg_data;
                    CFG_OCC_THRESHOLD: cost_limit     = i_cfg_data[6:0];
                    CFG_UNKNOWN_BLK:   unknown_blocks = i_cfg_data[0];
                    CFG_CLEARANCE:     clear_radius   = i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (i_req_valid && i_req_ready) begin
                want = '0;
                x    = int'(i_req.cell_x);
                y    = int'(i_req.cell_y);
                if (i_req.req_type == REQ_QUERY) begin
                    want.is_answer = 1'b1;
                    want.cell_safe = has_clearance(x, y);
                end else if (on_map(x, y)) begin
                    // blocked bit is judged with the settings of the moment
                    cost = int'($signed(i_req.cell_cost));
                    blocked_cells[y * ROW_STRIDE + x] =
                        (cost < 0) ? unknown_blocks : (cost >= int'(cost_limit));
                end
                answers_due.push_back(want);
            end

            if (i_rsp_valid && i_rsp_ready) begin
                o_results <= o_results + 1;
                if (answers_due.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("%t: result is_answer=%b cell_safe=%b with nothing outstanding",
                                 $realtime, i_rsp.is_answer, i_rsp.cell_safe);
                    end
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (i_rsp !== want) begin
                        if (o_mismatches < 10) begin
                            $display("%t: is_answer exp %b got %b, cell_safe exp %b got %b",
                                     $realtime, want.is_answer, i_rsp.is_answer,
                                     want.cell_safe, i_rsp.cell_safe);
                        end
                        o_mismatches <= o_mismatches + 1;
                    end else if (want.cell_safe) begin
                        o_safe_answers <= o_safe_answers + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/occupancy_clearance_erosion_unit_tb.sv
// Testbench top: drives writes, queries and register settings into the erosion unit.
module occupancy_clearance_erosion_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oce_pkg::*;

    localparam int STIM_ITEMS = 1500;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_ready;
    t_in        i_data      = '0;
    logic       o_valid;
    logic       i_ready     = 1'b0;
    t_out       o_data;
    logic       i_cfg_wr_en = 1'b0;
    logic [2:0] i_cfg_index = CFG_GRID_WIDTH;
    logic [8:0] i_cfg_data  = '0;

    int mismatches;
    int results;
    int safe_answers;

    // stimulus-side view of the map: which cells hold a defined bit
    bit cell_written [MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
    int map_cols       = 256;
    int map_rows       = 256;
    int cost_limit     = 20;
    bit unknown_blocks = 1'b1;
    int clear_radius   = 4;
    int sent           = 0;
    int queries        = 0;
    int settings       = 0;
    int idle_pct       = 0;
    bit calm           = 1'b0;

    occupancy_clearance_erosion_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    occupancy_clearance_erosion_checker answer_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_req          (i_data),
        .i_rsp_valid    (o_valid),
        .i_rsp_ready    (i_ready),
        .i_rsp          (o_data),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_results      (results),
        .o_safe_answers (safe_answers)
    );

    always #10 i_clk = ~i_clk;

    // a cost that lands on the wanted side under the current settings, where one exists
    function automatic logic [7:0] cost_for(bit want_blocked);
        bit negative;
        negative = $urandom_range(0, 1);
        if (want_blocked) begin
            if (unknown_blocks && negative) begin
                return 8'($urandom_range(128, 255));
            end
            return 8'($urandom_range(cost_limit, 127));
        end
        if (cost_limit > 0 && (unknown_blocks || negative)) begin
            return 8'($urandom_range(0, cost_limit - 1));
        end
        if (!unknown_blocks) begin
            return 8'($urandom_range(128, 255));
        end
        return 8'($urandom);
    endfunction

    task automatic send(logic kind, int x, int y, logic [7:0] cost);
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= t_in'{req_type: kind, cell_x: 8'(x), cell_y: 8'(y), cell_cost: cost};
        do @(posedge i_clk); while (!o_ready);
        sent++;
        if (kind == REQ_QUERY) begin
            queries++;
        end else if (x < map_cols && y < map_rows) begin
            cell_written[y * MAX_WIDTH_DEF + x] = 1'b1;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (results != sent) @(posedge i_clk);
    endtask

    task automatic configure(int cols, int rows, int limit, bit unk, int radius);
        logic [2:0] regs [5] = '{CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_OCC_THRESHOLD,
                                 CFG_UNKNOWN_BLK, CFG_CLEARANCE};
        logic [8:0] values [5];
        values[0] = 9'(cols);
        values[1] = 9'(rows);
        values[2] = 9'(limit);
        values[3] = 9'(unk);
        values[4] = 9'(radius);
        drain();
        for (int i = 0; i < 5; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= values[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en    <= 1'b0;
        map_cols       = (cols > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cols;
        map_rows       = (rows > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : rows;
        cost_limit     = limit;
        unknown_blocks = unk;
        clear_radius   = radius;
        settings++;
    endtask

    // every cell inside the map gets a defined bit before any query
    task automatic fill_map(int block_pct);
        for (int y = 0; y < map_rows; y++) begin
            for (int x = 0; x < map_cols; x++) begin
                if (!cell_written[y * MAX_WIDTH_DEF + x]) begin
                    send(REQ_WRITE, x, y, cost_for($urandom_range(0, 99) < block_pct));
                end
            end
        end
    endtask

    task automatic mixed_traffic(int count, int block_pct);
        int pick;
        int x;
        int y;
        bit on_map;
        on_map = map_cols > 0 && map_rows > 0;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55 && on_map) begin
                x = $urandom_range(0, map_cols - 1);
                y = $urandom_range(0, map_rows - 1);
                // bias toward cells whose whole disk fits on the map
                if (pick < 30 && map_cols > 2 * clear_radius && map_rows > 2 * clear_radius) begin
                    x = $urandom_range(clear_radius, map_cols - 1 - clear_radius);
                    y = $urandom_range(clear_radius, map_rows - 1 - clear_radius);
                end
                send(REQ_QUERY, x, y, 8'($urandom));
            end else if (pick < 80 && on_map) begin
                send(REQ_WRITE, $urandom_range(0, map_cols - 1), $urandom_range(0, map_rows - 1),
                     cost_for($urandom_range(0, 99) < block_pct));
            end else begin
                send(pick[0] ? REQ_QUERY : REQ_WRITE, $urandom_range(0, 255),
                     $urandom_range(0, 255), 8'($urandom));
            end
        end
    endtask

    // receiver: ready stalls in bursts, long open stretches, always open at the end
    initial begin
        @(posedge i_clk);
        forever begin
            if (calm || $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(20, 300)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int w;
        int h;
        int span;
        int limit;
        int radius;
        int block_pct;
        int budget;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unknown blocks, threshold edge at 20
        idle_pct = 20;
        send(REQ_WRITE, 0, 0, 8'h80);
        send(REQ_WRITE, 255, 255, 8'h7f);
        send(REQ_WRITE, 1, 0, 8'd19);
        send(REQ_WRITE, 2, 0, 8'd20);
        send(REQ_WRITE, 3, 0, 8'd0);
        send(REQ_WRITE, 0, 1, 8'hff);

        // tiny map, old blocked bits kept across the settings change
        configure(3, 3, 127, 1'b0, 0);
        fill_map(0);
        send(REQ_WRITE, 1, 1, 8'd126);
        send(REQ_QUERY, 1, 1, 8'h00);
        send(REQ_QUERY, 0, 0, 8'h55);
        send(REQ_QUERY, 3, 1, 8'h00);
        send(REQ_WRITE, 5, 5, 8'h01);
        configure(3, 3, 0, 1'b1, 1);
        send(REQ_WRITE, 2, 2, 8'h00);
        send(REQ_QUERY, 1, 1, 8'h00);

        // empty maps
        configure(0, 3, 20, 1'b1, 0);
        send(REQ_QUERY, 0, 0, 8'h00);
        send(REQ_WRITE, 0, 0, 8'h00);
        configure(3, 0, 20, 1'b1, 15);
        send(REQ_QUERY, 255, 255, 8'h00);

        budget = sent + STIM_ITEMS;

        // oversized extents saturate to one full row and one full column
        idle_pct = 10;
        configure(511, 1, $urandom_range(1, 127), $urandom_range(0, 1), 0);
        fill_map(3);
        mixed_traffic(60, 3);
        configure(1, 511, $urandom_range(1, 127), $urandom_range(0, 1), 15);
        fill_map(3);
        mixed_traffic(40, 3);
        configure(256, 1, $urandom_range(0, 127), $urandom_range(0, 1), 1);
        mixed_traffic(30, 10);

        while (sent < budget) begin
            w = $urandom_range(1, 20);
            h = $urandom_range(1, 20);
            case ($urandom_range(0, 9))
                0: w = 0;
                1: h = 0;
                2: begin
                    w = $urandom_range(16, 28);
                    h = $urandom_range(16, 28);
                end
                default: ;
            endcase
            span = ((w < h) ? w : h) / 2;
            if (span > 15) begin
                span = 15;
            end
            radius = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, span);
            limit  = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 127 : 0)
                                                  : $urandom_range(1, 60);
            case ($urandom_range(0, 4))
                0: block_pct = 0;
                1: block_pct = 1;
                2: block_pct = 3;
                3: block_pct = 10;
                default: block_pct = 30;
            endcase
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 5;
                2: idle_pct = 25;
                default: idle_pct = 60;
            endcase
            if (budget - sent <= 150) begin
                calm = 1'b1;
            end
            configure(w, h, limit, $urandom_range(0, 1), radius);
            fill_map(block_pct);
            mixed_traffic((budget - sent < 30) ? 30 : $urandom_range(30, 120), block_pct);
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d transfers in, %0d of them queries, %0d answered safe",
                 sent, queries, safe_answers);
        $display("over %0d register settings, from empty maps to saturated extents",
                 settings);
        if (mismatches == 0 && results == sent) begin
            $display("occupancy_clearance_erosion_unit test passed");
        end else begin
            $display("occupancy_clearance_erosion_unit test failed");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("occupancy_clearance_erosion_unit test failed");
        $finish;
    end

endmodule

### occupancy_clearance_erosion_unit.f
rtl/oce_pkg.sv
rtl/oce_row_mem.sv
rtl/occupancy_clearance_erosion_unit.sv
tb/occupancy_clearance_erosion_checker.sv
tb/occupancy_clearance_erosion_unit_tb.sv
